// ===== sv/step_sequence_controller_defines.svh =====
// ----------------------------------------------------------------------------
// Step sequence controller assertion macros
// Clocked, reset-gated property shorthands used by the port checker.
// ----------------------------------------------------------------------------
`ifndef STEP_SEQUENCE_CONTROLLER_DEFINES_SVH
`define STEP_SEQUENCE_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define SSC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("step sequence controller check failed");

// next-cycle implication
`define SSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("step sequence controller check failed");

`endif

// ===== sv/ssc_pkg.sv =====
// ----------------------------------------------------------------------------
// Step sequence controller package
// Types, constants and helpers shared by the sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ssc_pkg;

  localparam int SSC_MAX_STEPS = 10;
  localparam int SSC_STEP_W    = 4;
  localparam int SSC_MASK_W    = 10;
  localparam int SSC_CFG_IDX_W = 2;

  // register indexes on the config port
  typedef enum logic [SSC_CFG_IDX_W-1:0] {
    CFG_STEP_COUNT  = 2'd0,
    CFG_STATUS_MASK = 2'd1,
    CFG_ABORT_MASK  = 2'd2
  } ssc_cfg_idx_e;

  // overall sequencer state, also the child status coding
  typedef enum logic [1:0] {
    SEQ_DONE    = 2'd0,
    SEQ_RUNNING = 2'd1,
    SEQ_ABORTED = 2'd2
  } ssc_seq_e;

  typedef struct packed {
    logic       cmd;
    logic       start_set;
    logic       abort_set;
    logic       clear_level;
    logic [1:0] child_state;
    logic       child_read_fail;
    logic       request_write_fail;
  } ssc_in_t;

  typedef struct packed {
    logic [1:0]            seq_state;
    logic [SSC_STEP_W-1:0] step_index;
    logic                  waiting;
    logic                  request_issued;
    logic [SSC_STEP_W-1:0] request_step;
    logic                  abort_issued;
    logic                  major_alarm;
    logic                  finished;
    logic                  delay_started;
  } ssc_out_t;

  typedef struct packed {
    logic [SSC_STEP_W-1:0] step_count;
    logic [SSC_MASK_W-1:0] status_link_mask;
    logic [SSC_MASK_W-1:0] abort_link_mask;
  } ssc_cfg_t;

  typedef struct packed {
    ssc_seq_e              seq_state;
    logic [SSC_STEP_W-1:0] step;
    logic                  waiting;
    logic                  start_latch;
    logic                  abort_latch;
    logic                  delay_flag;
  } ssc_state_t;

  // per-step link bit; steps past the mask width have no link
  function automatic logic mask_bit(input logic [SSC_MASK_W-1:0] m,
                                    input logic [SSC_STEP_W-1:0] s);
    logic r;
    r = 1'b0;
    if (s < SSC_STEP_W'(SSC_MASK_W)) begin
      r = m[s];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/ssc_step_logic.sv =====
// ----------------------------------------------------------------------------
// Step sequence controller event logic
// Combinational next state and result for one event.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_step_logic
  import ssc_pkg::*;
#(
  parameter int MAX_STEPS = SSC_MAX_STEPS
) (
  input  ssc_cfg_t   cfg,
  input  ssc_state_t cur,
  input  ssc_in_t    evt_q,
  output ssc_state_t nxt,
  output ssc_out_t   res_next
);

  localparam logic [SSC_STEP_W-1:0] MaxIdx = SSC_STEP_W'(MAX_STEPS);

  logic [SSC_STEP_W-1:0] limit;
  logic                  sl, al, dly, go, child_abort;
  ssc_seq_e              st;
  logic [SSC_STEP_W-1:0] stp, req_stp;
  logic                  wf, req, abo, alm, fin;

  assign limit = (cfg.step_count < MaxIdx) ? cfg.step_count : MaxIdx;

  // next state
  always_comb begin
    sl          = cur.start_latch | evt_q.start_set;
    al          = cur.abort_latch | evt_q.abort_set;
    dly         = cur.delay_flag & ~evt_q.cmd;
    child_abort = ~evt_q.child_read_fail && (evt_q.child_state == SEQ_ABORTED);
    st          = cur.seq_state;
    stp         = cur.step;
    wf          = cur.waiting;
    go          = 1'b0;
    req         = 1'b0;
    req_stp     = '0;
    abo         = 1'b0;
    alm         = 1'b0;
    fin         = 1'b0;

    if (!dly) begin
      go = 1'b1;
      if (evt_q.clear_level && st == SEQ_ABORTED) begin
        st  = SEQ_DONE;
        stp = '0;
      end
      if (st != SEQ_RUNNING) begin
        al = 1'b0;
        if (!sl) begin
          go = 1'b0;
        end else begin
          st  = SEQ_RUNNING;
          stp = '0;
          wf  = 1'b0;
        end
      end
      if (go) begin
        sl = 1'b0;
        if (wf) begin
          if (evt_q.child_read_fail || child_abort || al) begin
            st  = SEQ_ABORTED;
            alm = 1'b1;
            if (al && !child_abort) begin
              abo = mask_bit(cfg.abort_link_mask, stp);
              al  = 1'b0;
            end
            go = 1'b0;
          end else if (evt_q.child_state != SEQ_DONE) begin
            go = 1'b0;   // child still running (code three counts as running)
          end else begin
            stp = stp + 1'b1;
            wf  = 1'b0;
          end
        end
      end
      if (go) begin
        if (stp >= MaxIdx || stp >= limit) begin
          st  = SEQ_DONE;
          stp = '0;
          fin = 1'b1;
        end else begin
          req     = 1'b1;
          req_stp = stp;
          if (evt_q.request_write_fail) begin
            st  = SEQ_ABORTED;
            alm = 1'b1;
          end else if (mask_bit(cfg.status_link_mask, stp)) begin
            wf = 1'b1;
          end else begin
            stp = stp + 1'b1;
          end
        end
      end
    end

    nxt.seq_state   = st;
    nxt.step        = stp;
    nxt.waiting     = wf;
    nxt.start_latch = sl;
    nxt.abort_latch = al;
    nxt.delay_flag  = dly | req;
  end

  // result beat
  always_comb begin
    res_next.seq_state      = nxt.seq_state;
    res_next.step_index     = nxt.step;
    res_next.waiting        = nxt.waiting;
    res_next.request_issued = req;
    res_next.request_step   = req_stp;
    res_next.abort_issued   = abo;
    res_next.major_alarm    = alm;
    res_next.finished       = fin;
    res_next.delay_started  = req;
  end

endmodule

`default_nettype wire

// ===== sv/step_sequence_controller.sv =====
// ----------------------------------------------------------------------------
// Step sequence controller
// Runs up to MAX_STEPS child steps in order, one event beat per cycle unless stalled.
// ----------------------------------------------------------------------------
//  channel  | signals                               | direction
//  ---------+---------------------------------------+----------
//  evt      | evt_valid, evt_stall, evt (ssc_in_t)  | in
//  res      | res_valid, res_stall, res (ssc_out_t) | out
//  cfg      | cfg_valid, cfg_ready, cfg_index/data  | in
//
//  One event beat enters per cycle while evt_stall is low; its result beat
//  goes through the input register, then the result register. The step logic
//  reads the sequencer state updated by the previous beat in the same cycle.
//  Reset (rst, synchronous) clears valids, sequencer state and config.
//  A stalled result holds; evt_stall rises only while a beat waits in the
//  input register behind a stalled result. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module step_sequence_controller
  import ssc_pkg::*;
#(
  parameter int MAX_STEPS = SSC_MAX_STEPS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     evt_valid,
  output logic                     evt_stall,
  input  ssc_in_t                  evt,
  output logic                     res_valid,
  input  logic                     res_stall,
  output ssc_out_t                 res,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [SSC_CFG_IDX_W-1:0] cfg_index,
  input  logic [SSC_MASK_W-1:0]    cfg_data
);

  ssc_in_t    evt_q;
  logic       evt_q_valid;
  ssc_state_t state, state_next;
  ssc_cfg_t   cfg;
  ssc_out_t   res_next;
  logic       advance;

  // result slot is busy when it holds a beat that is not taken this cycle
  assign evt_stall = evt_q_valid && res_valid && res_stall;
  assign advance   = evt_q_valid && !(res_valid && res_stall);
  assign cfg_ready = 1'b1;

  // config registers; index past the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_STEP_COUNT:  cfg.step_count       <= cfg_data[SSC_STEP_W-1:0];
        CFG_STATUS_MASK: cfg.status_link_mask <= cfg_data;
        CFG_ABORT_MASK:  cfg.abort_link_mask  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      evt_q_valid <= 1'b0;
    end else if (!evt_stall) begin
      evt_q_valid <= evt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_valid && !evt_stall) begin
      evt_q <= evt;
    end
  end

  ssc_step_logic #(
    .MAX_STEPS (MAX_STEPS)
  ) u_step (
    .cfg      (cfg),
    .cur      (state),
    .evt_q    (evt_q),
    .nxt      (state_next),
    .res_next (res_next)
  );

  // sequencer state moves with each beat handed to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state.seq_state   <= SEQ_DONE;
      state.step        <= '0;
      state.waiting     <= 1'b0;
      state.start_latch <= 1'b0;
      state.abort_latch <= 1'b0;
      state.delay_flag  <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ssc_checker.sv =====
// ----------------------------------------------------------------------------
// Step sequence controller port checker
// Watches the event and result channels of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "step_sequence_controller_defines.svh"

module ssc_checker
  import ssc_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     evt_stall,
  input logic     res_valid,
  input logic     res_stall,
  input ssc_out_t res
);

  logic idle_home;

  assign idle_home = (res.seq_state == SEQ_DONE) && (res.step_index == '0);

  // stalled result beat holds
  `SSC_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res))

  // input backs up only behind a stalled result
  `SSC_ASSERT_NOW(a_stall_cause, evt_stall, res_valid && res_stall)

  // finishing leaves the sequencer idle at step zero
  `SSC_ASSERT_NOW(a_finish_idle, res_valid && res.finished, idle_home)

  // alarm only on entering aborted
  `SSC_ASSERT_NOW(a_alarm_abort, res_valid && res.major_alarm, res.seq_state == SEQ_ABORTED)

  // every request starts the settle delay
  `SSC_ASSERT_NOW(a_req_delay, res_valid, res.request_issued == res.delay_started)

endmodule

bind step_sequence_controller ssc_checker u_ssc_checker (.*);

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// Step sequence controller testbench
// Drives event beats through the sequencer under a range of step counts and
// link masks. A local copy of the sequencer tracks state and config and
// predicts the status beat for every event. Both channels idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import ssc_pkg::*;

  // child status code outside the three named states; reads as running
  localparam logic [1:0] CHILD_UNKNOWN = 2'd3;
  // config index with no register behind it
  localparam logic [SSC_CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
  localparam int PHASE_BEATS = 42;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     evt_valid = 1'b0;
  logic                     evt_stall;
  ssc_in_t                  evt = '0;
  logic                     res_valid;
  logic                     res_stall = 1'b0;
  ssc_out_t                 res;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [SSC_CFG_IDX_W-1:0] cfg_index = '0;
  logic [SSC_MASK_W-1:0]    cfg_data = '0;

  step_sequence_controller dut (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Local sequencer copy: config and state, same reset values as the block
  // --------------------------------------------------------------------------
  logic [SSC_STEP_W-1:0] cfg_steps       = '0;
  logic [SSC_MASK_W-1:0] cfg_status_mask = '0;
  logic [SSC_MASK_W-1:0] cfg_abort_mask  = '0;

  ssc_seq_e              seq_now     = SEQ_DONE;
  logic [SSC_STEP_W-1:0] step_now    = '0;
  logic                  waiting_now = 1'b0;
  logic                  start_held  = 1'b0;
  logic                  abort_held  = 1'b0;
  logic                  delay_on    = 1'b0;

  ssc_in_t  event_q[$];   // events not yet put on the bus
  ssc_out_t status_q[$];  // predicted status beats, oldest first

  int errors     = 0;
  int evt_gap    = 0;
  int stall_left = 0;
  bit quiet      = 1'b0;  // no idling on either side while set

  // steps at or past the mask width have no link
  function automatic logic has_link(input logic [SSC_MASK_W-1:0] m,
                                    input logic [SSC_STEP_W-1:0] s);
    logic r;
    r = 1'b0;
    if (s < SSC_MASK_W) begin
      r = m[s];
    end
    return r;
  endfunction

  // One event through the sequencer; returns the status beat it produces.
  function automatic ssc_out_t advance_sequence(input ssc_in_t ev);
    ssc_out_t              r;
    logic                  go;
    logic                  child_abort;
    logic [SSC_STEP_W-1:0] lim;
    r   = '0;
    lim = (cfg_steps < SSC_MAX_STEPS) ? cfg_steps : SSC_STEP_W'(SSC_MAX_STEPS);
    // requests latch first, expiry clears the delay before processing
    if (ev.start_set) start_held = 1'b1;
    if (ev.abort_set) abort_held = 1'b1;
    if (ev.cmd) delay_on = 1'b0;
    if (!delay_on) begin
      go = 1'b1;
      if (ev.clear_level && seq_now == SEQ_ABORTED) begin
        seq_now  = SEQ_DONE;
        step_now = '0;
      end
      if (seq_now != SEQ_RUNNING) begin
        // idle: stale abort is dropped, only a start gets things moving
        abort_held = 1'b0;
        if (!start_held) begin
          go = 1'b0;
        end else begin
          seq_now     = SEQ_RUNNING;
          step_now    = '0;
          waiting_now = 1'b0;
        end
      end
      if (go) begin
        start_held = 1'b0;
        if (waiting_now) begin
          child_abort = !ev.child_read_fail && ev.child_state == SEQ_ABORTED;
          if (ev.child_read_fail || child_abort || abort_held) begin
            seq_now       = SEQ_ABORTED;
            r.major_alarm = 1'b1;
            // our own abort goes down to the child unless it aborted itself
            if (abort_held && !child_abort) begin
              r.abort_issued = has_link(cfg_abort_mask, step_now);
              abort_held     = 1'b0;
            end
            go = 1'b0;
          end else if (ev.child_state != SEQ_DONE) begin
            go = 1'b0;
          end else begin
            step_now    = step_now + 1'b1;
            waiting_now = 1'b0;
          end
        end
      end
      if (go) begin
        if (step_now >= SSC_MAX_STEPS || step_now >= lim) begin
          seq_now    = SEQ_DONE;
          step_now   = '0;
          r.finished = 1'b1;
        end else begin
          r.request_issued = 1'b1;
          r.request_step   = step_now;
          r.delay_started  = 1'b1;
          delay_on         = 1'b1;
          if (ev.request_write_fail) begin
            seq_now       = SEQ_ABORTED;
            r.major_alarm = 1'b1;
          end else if (has_link(cfg_status_mask, step_now)) begin
            waiting_now = 1'b1;
          end else begin
            step_now = step_now + 1'b1;
          end
        end
      end
    end
    r.seq_state  = seq_now;
    r.step_index = step_now;
    r.waiting    = waiting_now;
    return r;
  endfunction

  function automatic string show_status(input ssc_out_t r);
    return {$sformatf("state=%0d step=%0d wait=%0b req=%0b/%0d ",
                      r.seq_state, r.step_index, r.waiting, r.request_issued,
                      r.request_step),
            $sformatf("abort=%0b alarm=%0b fin=%0b dly=%0b",
                      r.abort_issued, r.major_alarm, r.finished,
                      r.delay_started)};
  endfunction

  function automatic bit status_matches(input ssc_out_t a, input ssc_out_t b);
    return a.seq_state === b.seq_state && a.step_index === b.step_index &&
           a.waiting === b.waiting && a.request_issued === b.request_issued &&
           a.request_step === b.request_step && a.abort_issued === b.abort_issued &&
           a.major_alarm === b.major_alarm && a.finished === b.finished &&
           a.delay_started === b.delay_started;
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  // mostly zero or short, now and then a long hold-off
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // --------------------------------------------------------------------------
  // Event driver: one beat per accepted handshake, prediction at acceptance
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
      evt_gap   <= 0;
    end else begin
      if (evt_valid && !evt_stall) status_q.push_back(advance_sequence(evt));
      if (evt_valid && evt_stall) begin
        // stalled beat holds as is
      end else if (evt_gap != 0) begin
        evt_valid <= 1'b0;
        evt_gap   <= evt_gap - 1;
      end else if (event_q.size() != 0) begin
        evt_valid <= 1'b1;
        evt       <= event_q.pop_front();
        evt_gap   <= idle_len();
      end else begin
        evt_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Status monitor: compare each accepted beat against the oldest prediction
  // --------------------------------------------------------------------------
  ssc_out_t status_want;

  always @(posedge clk) begin
    if (rst) begin
      res_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (status_q.size() == 0) begin
          flag_error($sformatf("unexpected status beat: %s", show_status(res)));
        end else begin
          status_want = status_q.pop_front();
          if (!status_matches(res, status_want))
            flag_error($sformatf("status mismatch\n  exp %s\n  got %s",
                                 show_status(status_want), show_status(res)));
        end
      end
      if (stall_left != 0) begin
        res_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        res_stall <= 1'b0;
        if ($urandom_range(0, 3) == 0) stall_left <= idle_len();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic ssc_in_t mk(input logic cmd, input logic st, input logic ab,
                                 input logic clr, input logic [1:0] child,
                                 input logic rdf, input logic wrf);
    ssc_in_t ev;
    ev.cmd                = cmd;
    ev.start_set          = st;
    ev.abort_set          = ab;
    ev.clear_level        = clr;
    ev.child_state        = child;
    ev.child_read_fail    = rdf;
    ev.request_write_fail = wrf;
    return ev;
  endfunction

  // config only changes with nothing in flight
  task automatic write_reg(input logic [SSC_CFG_IDX_W-1:0] idx,
                           input logic [SSC_MASK_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_STEP_COUNT:  cfg_steps       = val[SSC_STEP_W-1:0];
      CFG_STATUS_MASK: cfg_status_mask = val;
      CFG_ABORT_MASK:  cfg_abort_mask  = val;
      default: ;
    endcase
  endtask

  // sender holds off until every predicted beat has come back; checked
  // between edges so queue and valid updates have settled
  task automatic drain();
    @(negedge clk);
    while (event_q.size() != 0 || evt_valid || status_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // start beat, then mostly expiry beats with children finishing normally
  task automatic queue_run(output int n);
    ssc_in_t ev;
    int      r;
    n  = $urandom_range(2, 2 * SSC_MAX_STEPS + 4);
    ev = mk(1'($urandom_range(0, 1)), 1'b1, 1'b0, $urandom_range(0, 4) != 0,
            SEQ_DONE, 1'b0, 1'b0);
    event_q.push_back(ev);
    repeat (n) begin
      r  = $urandom_range(0, 9);
      ev = mk($urandom_range(0, 9) != 0, $urandom_range(0, 29) == 0,
              $urandom_range(0, 39) == 0, $urandom_range(0, 19) == 0,
              (r < 6) ? SEQ_DONE : (r < 8) ? SEQ_RUNNING :
              (r == 8) ? SEQ_ABORTED : CHILD_UNKNOWN,
              $urandom_range(0, 29) == 0, $urandom_range(0, 29) == 0);
      event_q.push_back(ev);
    end
    n = n + 1;
  endtask

  initial begin
    int queued;
    int n;
    int k;
    logic [7:0] noise;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset config: zero steps, so a start finishes at once
    @(negedge clk);
    event_q.push_back(mk(1'b0, 1'b0, 1'b0, 1'b0, SEQ_DONE, 1'b0, 1'b0));
    event_q.push_back(mk(1'b0, 1'b1, 1'b0, 1'b0, SEQ_DONE, 1'b0, 1'b0));
    drain();

    // three steps; steps 1 and 2 wait on children, only step 1 can be aborted
    write_reg(CFG_STEP_COUNT, 10'd3);
    write_reg(CFG_STATUS_MASK, 10'b110);
    write_reg(CFG_ABORT_MASK, 10'b010);
    @(negedge clk);
    // start, step 0
    event_q.push_back(mk(1'b1, 1'b1, 1'b0, 1'b0, SEQ_DONE, 1'b0, 1'b0));
    // during delay
    event_q.push_back(mk(1'b0, 1'b0, 1'b1, 1'b0, SEQ_DONE, 1'b0, 1'b0));
    // abort held, not waiting
    event_q.push_back(mk(1'b1, 1'b0, 1'b0, 1'b0, SEQ_DONE, 1'b0, 1'b0));
    // held abort goes to child
    event_q.push_back(mk(1'b1, 1'b0, 1'b0, 1'b0, SEQ_RUNNING, 1'b0, 1'b0));
    // clear
    event_q.push_back(mk(1'b1, 1'b0, 1'b0, 1'b1, SEQ_DONE, 1'b0, 1'b0));
    // request write fails
    event_q.push_back(mk(1'b1, 1'b1, 1'b0, 1'b0, SEQ_DONE, 1'b0, 1'b1));
    event_q.push_back(mk(1'b1, 1'b1, 1'b0, 1'b1, SEQ_DONE, 1'b0, 1'b0));
    event_q.push_back(mk(1'b1, 1'b0, 1'b0, 1'b0, SEQ_DONE, 1'b0, 1'b0));
    // odd child code
    event_q.push_back(mk(1'b1, 1'b0, 1'b0, 1'b0, CHILD_UNKNOWN, 1'b0, 1'b0));
    // read fail + abort
    event_q.push_back(mk(1'b1, 1'b0, 1'b1, 1'b0, SEQ_ABORTED, 1'b1, 1'b0));
    event_q.push_back(mk(1'b1, 1'b1, 1'b0, 1'b1, SEQ_DONE, 1'b0, 1'b0));
    event_q.push_back(mk(1'b1, 1'b0, 1'b0, 1'b0, SEQ_DONE, 1'b0, 1'b0));
    // child aborts
    event_q.push_back(mk(1'b1, 1'b0, 1'b0, 1'b0, SEQ_ABORTED, 1'b0, 1'b0));
    event_q.push_back(mk(1'b1, 1'b1, 1'b0, 1'b1, SEQ_DONE, 1'b0, 1'b0));
    event_q.push_back(mk(1'b1, 1'b0, 1'b0, 1'b0, SEQ_DONE, 1'b0, 1'b0));
    event_q.push_back(mk(1'b1, 1'b0, 1'b0, 1'b0, SEQ_DONE, 1'b0, 1'b0));
    // abort, no abort link
    event_q.push_back(mk(1'b1, 1'b0, 1'b1, 1'b0, SEQ_RUNNING, 1'b0, 1'b0));
    event_q.push_back(mk(1'b1, 1'b1, 1'b0, 1'b1, SEQ_DONE, 1'b0, 1'b0));
    event_q.push_back(mk(1'b1, 1'b0, 1'b0, 1'b0, SEQ_DONE, 1'b0, 1'b0));
    event_q.push_back(mk(1'b1, 1'b0, 1'b0, 1'b0, SEQ_DONE, 1'b0, 1'b0));
    // runs off the end
    event_q.push_back(mk(1'b1, 1'b0, 1'b0, 1'b0, SEQ_DONE, 1'b0, 1'b0));
    event_q.push_back(ssc_in_t'(8'hFF));
    drain();

    // random phases over a spread of settings
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
          write_reg(CFG_STEP_COUNT, 10'd10);
          write_reg(CFG_STATUS_MASK, 10'h3FF);
          write_reg(CFG_ABORT_MASK, 10'h3FF);
        end
        1: begin
          // count past the maximum, no waiting: runs all the way to the cap
          write_reg(CFG_STEP_COUNT, 10'd15);
          write_reg(CFG_STATUS_MASK, 10'h000);
          write_reg(CFG_ABORT_MASK, 10'($urandom));
          write_reg(CFG_SPARE_IDX, 10'($urandom));
        end
        2: begin
          write_reg(CFG_STEP_COUNT, 10'd0);
          write_reg(CFG_STATUS_MASK, 10'($urandom));
          write_reg(CFG_ABORT_MASK, 10'($urandom));
        end
        3: begin
          write_reg(CFG_STEP_COUNT, 10'd1);
          write_reg(CFG_STATUS_MASK, 10'h001);
          write_reg(CFG_ABORT_MASK, 10'h000);
        end
        default: begin
          write_reg(CFG_STEP_COUNT, 10'($urandom_range(0, 15)));
          write_reg(CFG_STATUS_MASK, 10'($urandom));
          write_reg(CFG_ABORT_MASK, 10'($urandom));
        end
      endcase
      quiet = (p % 3 == 1);
      @(negedge clk);
      queued = 0;
      while (queued < PHASE_BEATS) begin
        if ($urandom_range(0, 4) != 0) begin
          queue_run(n);
          queued += n;
        end else begin
          k = $urandom_range(1, 4);
          repeat (k) begin
            noise = 8'($urandom);
            event_q.push_back(ssc_in_t'(noise));
          end
          queued += k;
        end
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (errors == 0 && status_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #1000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== step_sequence_controller.f =====
+incdir+sv
sv/ssc_pkg.sv
sv/ssc_step_logic.sv
sv/step_sequence_controller.sv
sv/ssc_checker.sv
sim/tb.sv
